// File: hdl/hbd_pkg.sv
// Shared types and constants of the heart beat detector.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

   localparam int SAMPLE_W = 10;
   localparam int THR_W    = 10;
   localparam int IVL_W    = 12;
   localparam int BPM_W    = 8;
   localparam int SII_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 12;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_INTERVAL = 2'd0,
      CSR_DEFAULT_THRESHOLD = 2'd1,
      CSR_REFRACTORY = 2'd2,
      CSR_TIMEOUT = 2'd3
   } csr_index_type;

   localparam logic [SII_W-1:0] SAMPLE_INTERVAL_RESET = 8'd2;
   localparam logic [THR_W-1:0] DEFAULT_THRESHOLD_RESET = 10'd750;
   localparam logic [IVL_W-1:0] REFRACTORY_RESET = 12'd250;
   localparam logic [IVL_W-1:0] TIMEOUT_RESET = 12'd2500;

   localparam logic [THR_W-1:0] LEVEL_MID = 10'd512;
   localparam logic [THR_W-1:0] LEVEL_MAX = 10'd1023;
   localparam logic [IVL_W-1:0] INTERVAL_RESET = 12'd750;
   localparam logic [IVL_W-1:0] INTERVAL_TIMEOUT = 12'd600;
   localparam logic [IVL_W-1:0] ELAPSED_MAX = 12'd4095;

   // x / 5 == (x * 3277) >> 14 for every 12-bit x.
   localparam logic [IVL_W-1:0] DIV5_MUL = 12'd3277;
   localparam int DIV5_SHIFT = 14;

   // Rate division: 60000 / mean, saturating at 255 for means below 236.
   localparam int DVD_W = 16;
   localparam logic [DVD_W-1:0] BPM_DIVIDEND = 16'd60000;
   localparam int DIV_STEPS = 16;
   localparam logic [IVL_W-1:0] MEAN_SAT = 12'd236;
   localparam logic [BPM_W-1:0] BPM_MAX = 8'd255;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [SII_W-1:0] sample_interval_ms;
      logic [THR_W-1:0] default_threshold;
      logic [IVL_W-1:0] refractory_ms;
      logic [IVL_W-1:0] timeout_ms;
   } cfg_type;

   // What the back end has to do with the rate for one sample.
   typedef enum logic [1:0] {
      KIND_KEEP,
      KIND_CLEAR,
      KIND_DIVIDE
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic beat;
      logic pulse;
      logic [IVL_W-1:0] interval;
      logic [THR_W-1:0] threshold;
   } item_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MULT,
      BK_MEAN,
      BK_DIV,
      BK_OUT
   } back_state_type;

endpackage

`default_nettype wire

// File: hdl/hbd_front.sv
// Front end: takes one sample per transfer and updates the beat tracking state.
// Depends on hbd_pkg; pushes one classified item per sample into the queue.
`timescale 1ns / 1ps
`default_nettype none

module hbd_front
   import hbd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 10,
   localparam int SUM_W = IVL_W + $clog2(HISTORY_DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                accept,
   input  wire logic [SAMPLE_W-1:0] sample,
   output item_type                 item,
   output logic [SUM_W-1:0]         sum
);

   logic [IVL_W-1:0] tsb_ff, tsb_in;
   logic [IVL_W-1:0] last_ff, last_in;
   logic [THR_W-1:0] peak_ff, peak_in;
   logic [THR_W-1:0] trough_ff, trough_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic             pulse_ff, pulse_in;
   logic             first_ff, first_in;
   logic             second_ff, second_in;
   logic [IVL_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [IVL_W-1:0] hist_in [HISTORY_DEPTH];
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic [IVL_W:0]     elapsed_raw;
   logic [IVL_W-1:0]   elapsed;
   logic [2*IVL_W-1:0] div5_prod;
   logic [THR_W-1:0]   div5;
   logic [IVL_W-1:0]   guard;
   logic [THR_W-1:0]   peak_upd, trough_upd;
   logic               beat_cond, first_beat;
   logic signed [THR_W:0]   amp, half;
   logic signed [THR_W+1:0] mid;
   kind_type           kind;
   logic               beat;

   always_comb begin
      elapsed_raw = {1'b0, tsb_ff} + (IVL_W+1)'(cfg.sample_interval_ms);
      elapsed = elapsed_raw[IVL_W] ? ELAPSED_MAX : elapsed_raw[IVL_W-1:0];
      div5_prod = (2*IVL_W)'(last_ff) * (2*IVL_W)'(DIV5_MUL);
      div5 = div5_prod[DIV5_SHIFT +: THR_W];
      guard = (IVL_W'(div5) << 1) + IVL_W'(div5);

      trough_upd = trough_ff;
      if (sample < thr_ff && elapsed > guard && sample < trough_ff) begin
         trough_upd = sample;
      end
      peak_upd = peak_ff;
      if (sample > thr_ff && sample > peak_ff) begin
         peak_upd = sample;
      end

      beat_cond = elapsed > cfg.refractory_ms && sample > thr_ff && !pulse_ff &&
                  elapsed > guard;
      first_beat = beat_cond && first_ff;

      // Midpoint of peak and trough, division truncating toward zero.
      amp = $signed({1'b0, peak_upd}) - $signed({1'b0, trough_upd});
      half = (amp + ((amp < 0) ? (THR_W+1)'(1) : (THR_W+1)'(0))) >>> 1;
      mid = (THR_W+2)'(half) + $signed({2'b00, trough_upd});
   end

   always_comb begin
      tsb_in = elapsed;
      last_in = last_ff;
      peak_in = peak_upd;
      trough_in = trough_upd;
      thr_in = thr_ff;
      pulse_in = pulse_ff;
      first_in = first_ff;
      second_in = second_ff;
      hist_in = hist_ff;
      sum_in = sum_ff;
      kind = KIND_KEEP;
      beat = 1'b0;

      if (beat_cond) begin
         pulse_in = 1'b1;
         last_in = elapsed;
         tsb_in = '0;
         if (first_ff) begin
            first_in = 1'b0;
            second_in = 1'b1;
         end else begin
            // A second beat seeds the whole history with its interval.
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
               hist_in[i] = second_ff ? elapsed : hist_ff[i+1];
            end
            hist_in[HISTORY_DEPTH-1] = elapsed;
            if (second_ff) begin
               sum_in = SUM_W'(elapsed) * SUM_W'(HISTORY_DEPTH);
            end else begin
               sum_in = sum_ff - SUM_W'(hist_ff[0]) + SUM_W'(elapsed);
            end
            second_in = 1'b0;
            kind = KIND_DIVIDE;
            beat = 1'b1;
         end
      end

      if (!first_beat) begin
         if (sample < thr_ff && pulse_ff) begin
            priority if (mid < 0) begin
               thr_in = '0;
            end else if (mid > $signed({2'b00, LEVEL_MAX})) begin
               thr_in = LEVEL_MAX;
            end else begin
               thr_in = mid[THR_W-1:0];
            end
            pulse_in = 1'b0;
            peak_in = thr_in;
            trough_in = thr_in;
         end
         if (elapsed > cfg.timeout_ms) begin
            thr_in = cfg.default_threshold;
            peak_in = LEVEL_MID;
            trough_in = LEVEL_MID;
            tsb_in = '0;
            first_in = 1'b1;
            second_in = 1'b0;
            beat = 1'b0;
            kind = KIND_CLEAR;
            last_in = INTERVAL_TIMEOUT;
            pulse_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsb_ff <= '0;
         last_ff <= INTERVAL_RESET;
         peak_ff <= LEVEL_MID;
         trough_ff <= LEVEL_MID;
         thr_ff <= DEFAULT_THRESHOLD_RESET;
         pulse_ff <= 1'b0;
         first_ff <= 1'b1;
         second_ff <= 1'b0;
      end else if (accept) begin
         tsb_ff <= tsb_in;
         last_ff <= last_in;
         peak_ff <= peak_in;
         trough_ff <= trough_in;
         thr_ff <= thr_in;
         pulse_ff <= pulse_in;
         first_ff <= first_in;
         second_ff <= second_in;
      end
   end

   // The history is read only after a second beat has seeded it.
   always_ff @(posedge clock) begin
      if (accept) begin
         hist_ff <= hist_in;
         sum_ff <= sum_in;
      end
   end

   assign item.kind = kind;
   assign item.beat = beat;
   assign item.pulse = pulse_in;
   assign item.interval = last_in;
   assign item.threshold = thr_in;
   assign sum = sum_in;

   // A counted beat always leaves the pulse flag set.
   a_beat_sets_pulse: assert property (@(posedge clock) disable iff (reset)
      accept && item.beat |=> pulse_ff)
      else $error("beat counted without pulse flag");

endmodule

`default_nettype wire

// File: hdl/hbd_queue.sv
// Short queue between the front end and the rate back end.
// Depends on hbd_pkg for its depth; payload width is a parameter.
`timescale 1ns / 1ps
`default_nettype none

module hbd_queue
   import hbd_pkg::*;
#(
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      head_data,
   output logic                   full,
   output logic                   empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign head_data = mem_ff[rd_ff];
   assign full = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

`default_nettype wire

// File: hdl/hbd_back.sv
// Back end: keeps the rate, works out the mean interval and 60000 / mean.
// Depends on hbd_pkg; reads items from the queue and drives the result channel.
`timescale 1ns / 1ps
`default_nettype none

module hbd_back
   import hbd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 10,
   localparam int SUM_W = IVL_W + $clog2(HISTORY_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             empty,
   input  wire item_type         head_item,
   input  wire logic [SUM_W-1:0] head_sum,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [BPM_W-1:0]      rsp_bpm,
   output logic                  rsp_beat_detected,
   output logic                  rsp_pulse_active,
   output logic [IVL_W-1:0]      rsp_interval_ms,
   output logic [THR_W-1:0]      rsp_threshold_now
);

   // floor(sum / depth) as a multiply by a rounded-up reciprocal.
   localparam int K = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int PROD_W = SUM_W + K;
   localparam logic [K-1:0] RECIP = K'(((1 << K) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
   localparam int CNT_W = $clog2(DIV_STEPS);

   back_state_type state_ff, state_in;
   logic [BPM_W-1:0]  bpm_ff, bpm_in;
   item_type          item_ff, item_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [IVL_W-1:0]  mean_ff, mean_in;
   logic [IVL_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [IVL_W-1:0] mean_w;
   logic [IVL_W:0]   trial;
   logic             qbit;

   assign mean_w = prod_ff[K +: IVL_W];
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign qbit = (trial >= {1'b0, mean_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               state_in = (head_item.kind == KIND_DIVIDE) ? BK_MULT : BK_OUT;
            end
         end
         BK_MULT: state_in = BK_MEAN;
         BK_MEAN: state_in = (mean_w < MEAN_SAT) ? BK_OUT : BK_DIV;
         BK_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (!rsp_stall) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop = (state_ff == BK_IDLE) && !empty;
      rsp_valid = (state_ff == BK_OUT);
   end

   always_comb begin
      bpm_in = bpm_ff;
      item_in = item_ff;
      sum_in = sum_ff;
      prod_in = prod_ff;
      mean_in = mean_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               item_in = head_item;
               sum_in = head_sum;
               if (head_item.kind == KIND_CLEAR) begin
                  bpm_in = '0;
               end
            end
         end
         BK_MULT: prod_in = PROD_W'(sum_ff) * PROD_W'(RECIP);
         BK_MEAN: begin
            // Means below the limit, zero included, give a saturated rate.
            if (mean_w < MEAN_SAT) begin
               bpm_in = BPM_MAX;
            end
            mean_in = mean_w;
            rem_in = '0;
            dvd_in = BPM_DIVIDEND;
            cnt_in = '0;
         end
         BK_DIV: begin
            rem_in = qbit ? IVL_W'(trial - {1'b0, mean_ff}) : trial[IVL_W-1:0];
            dvd_in = {dvd_ff[DVD_W-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               bpm_in = dvd_in[BPM_W-1:0];
            end
         end
         BK_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         bpm_ff <= '0;
      end else begin
         state_ff <= state_in;
         bpm_ff <= bpm_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sum_ff <= sum_in;
      prod_ff <= prod_in;
      mean_ff <= mean_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_bpm = bpm_ff;
   assign rsp_beat_detected = item_ff.beat;
   assign rsp_pulse_active = item_ff.pulse;
   assign rsp_interval_ms = item_ff.interval;
   assign rsp_threshold_now = item_ff.threshold;

   // Every interval is below 4096 ms, so a counted beat never reports zero.
   a_beat_has_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat_detected |-> rsp_bpm != '0)
      else $error("beat reported with zero rate");

   // A timeout clears the rate before its result is shown.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_ff.kind == KIND_CLEAR |-> rsp_bpm == '0)
      else $error("timeout result with nonzero rate");

   // The divisor holds through all division steps.
   a_divisor_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DIV && $past(state_ff == BK_DIV) |-> $stable(mean_ff))
      else $error("divisor changed during division");

endmodule

`default_nettype wire

// File: hdl/heart_beat_detector_top.sv
// Top level of the heart beat detector: configuration registers, front end,
// queue and rate back end. Depends on hbd_pkg, hbd_front, hbd_queue, hbd_back.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         valid / stall      sample
//   rsp_      out        valid / stall      bpm, beat_detected, pulse_active,
//                                            interval_ms, threshold_now
//   csr_      in         valid / ready      index, wdata
//
// The front end takes a sample and queues its item in the same cycle. The back end
// sends a plain item to output; a counted beat passes queue, multiply, saturation
// check, sixteen division steps and output, skipping the division when the rate
// saturates. The four-entry queue lets the front end keep taking samples while the
// back end divides or the result side stalls; req_stall rises only when it fills.
// Synchronous active-high reset restores all but the history and data registers.
`timescale 1ns / 1ps
`default_nettype none

module heart_beat_detector_top
   import hbd_pkg::*;
#(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [SAMPLE_W-1:0]   req_sample,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [BPM_W-1:0]           rsp_bpm,
   output logic                       rsp_beat_detected,
   output logic                       rsp_pulse_active,
   output logic [IVL_W-1:0]           rsp_interval_ms,
   output logic [THR_W-1:0]           rsp_threshold_now,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W = IVL_W + $clog2(HISTORY_DEPTH);
   localparam int ITEM_W = $bits(item_type);
   localparam int QDATA_W = ITEM_W + SUM_W;

   cfg_type cfg_ff, cfg_in;

   logic             req_accept;
   item_type         front_item;
   logic [SUM_W-1:0] front_sum;
   logic             q_full, q_empty, q_pop;
   logic [QDATA_W-1:0] q_head;
   item_type         head_item;
   logic [SUM_W-1:0] head_sum;

   // Configuration writes are always taken; the user must issue them only while idle.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLE_INTERVAL: cfg_in.sample_interval_ms = csr_wdata[SII_W-1:0];
            CSR_DEFAULT_THRESHOLD: cfg_in.default_threshold = csr_wdata[THR_W-1:0];
            CSR_REFRACTORY: cfg_in.refractory_ms = csr_wdata[IVL_W-1:0];
            CSR_TIMEOUT: cfg_in.timeout_ms = csr_wdata[IVL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_interval_ms <= SAMPLE_INTERVAL_RESET;
         cfg_ff.default_threshold <= DEFAULT_THRESHOLD_RESET;
         cfg_ff.refractory_ms <= REFRACTORY_RESET;
         cfg_ff.timeout_ms <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end only advances when the queue has room for its item.
   assign req_stall = q_full;
   assign req_accept = req_valid && !q_full;

   hbd_front #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .accept(req_accept),
      .sample(req_sample),
      .item  (front_item),
      .sum   (front_sum)
   );

   hbd_queue #(
      .DATA_W(QDATA_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_data({front_sum, front_item}),
      .pop      (q_pop),
      .head_data(q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   assign head_item = q_head[ITEM_W-1:0];
   assign head_sum = q_head[QDATA_W-1:ITEM_W];

   // The back end owns the rate, so it applies timeouts and beats in order.
   hbd_back #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (q_empty),
      .head_item        (head_item),
      .head_sum         (head_sum),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_bpm          (rsp_bpm),
      .rsp_beat_detected(rsp_beat_detected),
      .rsp_pulse_active (rsp_pulse_active),
      .rsp_interval_ms  (rsp_interval_ms),
      .rsp_threshold_now(rsp_threshold_now)
   );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for heart_beat_detector_top: sample, result and register ports.
// Predicts every result from a cycle-free model of the beat tracker kept in this file.
// Depends on hbd_pkg and heart_beat_detector_top.
`timescale 1ns / 1ps

module testbench
   import hbd_pkg::*;
();

   localparam int HIST = 10;
   localparam int ELAPSED_CAP = 4095;
   localparam int RANDOM_TARGET = 1300;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;

   // One expected result transfer, field for field as the result port carries it.
   typedef struct packed {
      logic [BPM_W-1:0] bpm;
      logic             beat;
      logic             pulse;
      logic [IVL_W-1:0] interval;
      logic [THR_W-1:0] threshold;
   } beat_report_type;

   // A sample waiting to be sent. When drain is set, the sender holds it back until
   // every outstanding result has come out of the block.
   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      bit                  drain;
   } sample_slot_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BPM_W-1:0]      rsp_bpm;
   logic                  rsp_beat_detected;
   logic                  rsp_pulse_active;
   logic [IVL_W-1:0]      rsp_interval_ms;
   logic [THR_W-1:0]      rsp_threshold_now;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_SAMPLE_INTERVAL;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   heart_beat_detector_top #(
      .HISTORY_DEPTH(HIST)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bpm           (rsp_bpm),
      .rsp_beat_detected (rsp_beat_detected),
      .rsp_pulse_active  (rsp_pulse_active),
      .rsp_interval_ms   (rsp_interval_ms),
      .rsp_threshold_now (rsp_threshold_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------------
   // Beat tracker prediction. Register copies are updated from the register port
   // as writes are accepted, so the tracker always sees what the block sees.
   // ---------------------------------------------------------------------------
   logic [SII_W-1:0] sample_ms;
   logic [THR_W-1:0] dflt_thr;
   logic [IVL_W-1:0] refractory_ms;
   logic [IVL_W-1:0] timeout_ms;

   logic [IVL_W-1:0] since_beat;
   logic [IVL_W-1:0] last_ivl;
   logic [IVL_W-1:0] ivl_hist [HIST];
   logic [THR_W-1:0] peak;
   logic [THR_W-1:0] trough;
   logic [THR_W-1:0] thr_level;
   logic             pulse;
   logic             want_first;
   logic             want_second;
   logic [BPM_W-1:0] rate;

   int beats_counted = 0;
   int timeouts_seen = 0;

   function automatic beat_report_type track_sample(input logic [SAMPLE_W-1:0] smp);
      int elapsed;
      int guard;
      int sum;
      int mean;
      int quotient;
      int level;
      bit beat;
      bit first_beat;
      beat_report_type rep;
      elapsed = int'(since_beat) + int'(sample_ms);
      if (elapsed > ELAPSED_CAP) elapsed = ELAPSED_CAP;
      since_beat = IVL_W'(elapsed);
      // A new beat must also wait for three fifths of the previous interval.
      guard = (int'(last_ivl) / 5) * 3;
      beat = 1'b0;
      first_beat = 1'b0;

      if (smp < thr_level && elapsed > guard && smp < trough) trough = smp;
      if (smp > thr_level && smp > peak) peak = smp;

      if (elapsed > int'(refractory_ms) && smp > thr_level && !pulse && elapsed > guard) begin
         pulse = 1'b1;
         last_ivl = IVL_W'(elapsed);
         since_beat = '0;
         if (want_second) begin
            want_second = 1'b0;
            foreach (ivl_hist[i]) ivl_hist[i] = last_ivl;
         end
         if (want_first) begin
            // The first beat only starts the interval clock; nothing else this sample.
            want_first = 1'b0;
            want_second = 1'b1;
            first_beat = 1'b1;
         end else begin
            sum = 0;
            for (int i = 0; i < HIST - 1; i++) begin
               ivl_hist[i] = ivl_hist[i + 1];
               sum += int'(ivl_hist[i]);
            end
            ivl_hist[HIST - 1] = last_ivl;
            sum += int'(last_ivl);
            mean = sum / HIST;
            if (mean == 0) begin
               rate = BPM_MAX;
            end else begin
               quotient = int'(BPM_DIVIDEND) / mean;
               rate = (quotient > int'(BPM_MAX)) ? BPM_MAX : BPM_W'(quotient);
            end
            beat = 1'b1;
         end
      end

      if (!first_beat) begin
         if (smp < thr_level && pulse) begin
            level = (int'(peak) - int'(trough)) / 2 + int'(trough);
            if (level < 0) level = 0;
            if (level > int'(LEVEL_MAX)) level = int'(LEVEL_MAX);
            pulse = 1'b0;
            thr_level = THR_W'(level);
            peak = thr_level;
            trough = thr_level;
         end
         // The timeout looks at the elapsed time from before any beat in this
         // sample, so it can cancel a beat that was just counted.
         if (elapsed > int'(timeout_ms)) begin
            thr_level = dflt_thr;
            peak = LEVEL_MID;
            trough = LEVEL_MID;
            since_beat = '0;
            want_first = 1'b1;
            want_second = 1'b0;
            beat = 1'b0;
            rate = '0;
            last_ivl = INTERVAL_TIMEOUT;
            pulse = 1'b0;
            timeouts_seen++;
         end
      end

      if (beat) beats_counted++;
      rep.bpm = rate;
      rep.beat = beat;
      rep.pulse = pulse;
      rep.interval = last_ivl;
      rep.threshold = thr_level;
      return rep;
   endfunction

   // ---------------------------------------------------------------------------
   // Shared state of the driver, the monitor and the stimulus sequence.
   // ---------------------------------------------------------------------------
   beat_report_type reports_due[$];
   sample_slot_type samples_to_send[$];

   logic        req_fire = 1'b0;
   logic [15:0] stall_pattern = '0;
   logic [3:0]  stall_phase = '0;
   int gap_max = 0;
   int burst_max = 1;
   int gap_left = 0;
   int burst_left = 0;
   int fail_count = 0;
   int samples_taken = 0;
   int writes_done = 0;
   int random_items = 0;
   int quiet_cycles = 0;

   // Sample driver. All inputs change on the falling edge. A sample stays on the
   // port until the rising edge that takes it; req_fire tells us that edge happened.
   always @(negedge clock) begin : sample_driver
      sample_slot_type slot;
      rsp_stall <= stall_pattern[stall_phase];
      stall_phase <= stall_phase + 4'd1;
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (samples_to_send.size() != 0 &&
                      !(samples_to_send[0].drain && reports_due.size() != 0)) begin
            slot = samples_to_send.pop_front();
            req_valid <= 1'b1;
            req_sample <= slot.sample;
            // Count down the current burst; at its end, pick the next gap and burst.
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, burst_max);
               gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor. Everything is sampled on the rising edge: register writes update the
   // tracker copies, each sample transfer queues its expected result, and each
   // result transfer is checked against the oldest expectation.
   always @(posedge clock) begin : result_monitor
      beat_report_type want;
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_INTERVAL:   sample_ms = csr_wdata[SII_W-1:0];
               CSR_DEFAULT_THRESHOLD: dflt_thr = csr_wdata[THR_W-1:0];
               CSR_REFRACTORY:        refractory_ms = csr_wdata[IVL_W-1:0];
               CSR_TIMEOUT:           timeout_ms = csr_wdata[IVL_W-1:0];
               default: ;
            endcase
            writes_done++;
         end
         if (req_valid && !req_stall) begin
            reports_due.push_back(track_sample(req_sample));
            samples_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               $error("Result transfer arrived with no sample outstanding.");
               fail_count++;
            end else begin
               want = reports_due.pop_front();
               if (rsp_bpm !== want.bpm) begin
                  $error("bpm: expected %0d, got %0d", want.bpm, rsp_bpm);
                  fail_count++;
               end
               if (rsp_beat_detected !== want.beat) begin
                  $error("beat_detected: expected %0d, got %0d", want.beat, rsp_beat_detected);
                  fail_count++;
               end
               if (rsp_pulse_active !== want.pulse) begin
                  $error("pulse_active: expected %0d, got %0d", want.pulse, rsp_pulse_active);
                  fail_count++;
               end
               if (rsp_interval_ms !== want.interval) begin
                  $error("interval_ms: expected %0d, got %0d", want.interval, rsp_interval_ms);
                  fail_count++;
               end
               if (rsp_threshold_now !== want.threshold) begin
                  $error("threshold_now: expected %0d, got %0d", want.threshold,
                         rsp_threshold_now);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog. Any transfer on any port proves progress; a long silence means the
   // block has hung, and the run is ended as a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d results still due.",
                  quiet_cycles, reports_due.size());
         $display("heart_beat_detector_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------
   task automatic queue_sample(input int value, input bit drain);
      sample_slot_type slot;
      slot.sample = SAMPLE_W'(value);
      slot.drain = drain;
      samples_to_send.push_back(slot);
   endtask

   // Register write. The block keeps only the low bits of the narrow registers, so
   // the unused upper data bits get random values.
   task automatic write_reg(input csr_index_type idx, input int value);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'(value);
      if (idx == CSR_SAMPLE_INTERVAL) data[CSR_DATA_W-1:SII_W] = 4'($urandom);
      if (idx == CSR_DEFAULT_THRESHOLD) data[CSR_DATA_W-1:THR_W] = 2'($urandom);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Returns once every queued sample has been sent and every result checked.
   // Conditions are read just after the rising edge, when all updates have settled.
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (samples_to_send.size() != 0 || req_valid || reports_due.size() != 0);
   endtask

   // Idling style for one phase: sender gaps and bursts, and the receiver's stall
   // pattern, which is rotated one bit per cycle.
   task automatic choose_idling(input int mode);
      case (mode)
         0: begin
            gap_max = 0;
            burst_max = 1;
            stall_pattern = '0;
         end
         1: begin
            gap_max = 3;
            burst_max = 8;
            stall_pattern = 16'($urandom);
            stall_pattern[$urandom_range(0, 15)] = 1'b0;
         end
         2: begin
            gap_max = 12;
            burst_max = 3;
            stall_pattern = 16'h0FFF;
         end
         default: begin
            gap_max = 1;
            burst_max = 20;
            stall_pattern = 16'hAAAA;
         end
      endcase
   endtask

   // Synthetic pulse waveform: each beat is a short rise to a random peak followed
   // by a low stretch. Some samples are pure noise, and now and then a beat is
   // followed by a long flat stretch so that the beat timeout fires.
   task automatic queue_rhythm(input int budget, input int p_lo, input int p_hi);
      int p;
      int hi;
      int lo;
      int width;
      int flat;
      int v;
      int pushed;
      pushed = 0;
      while (pushed < budget) begin
         p = $urandom_range(p_lo, p_hi);
         hi = $urandom_range(500, 1023);
         lo = $urandom_range(0, 450);
         width = $urandom_range(1, (p > 3) ? 3 : p - 1);
         flat = ($urandom_range(0, 14) == 0) ? $urandom_range(p, 3 * p) : 0;
         for (int i = 0; i < p + flat; i++) begin
            if ($urandom_range(0, 11) == 0) v = $urandom_range(0, 1023);
            else if (i < width) v = hi - $urandom_range(0, 20);
            else v = lo + $urandom_range(0, 20);
            queue_sample(v, ($urandom_range(0, 149) == 0) || (random_items == 100));
            random_items++;
            pushed++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int si;
      int thr;
      int refr;
      int tmo;
      int p_lo;
      int p_hi;
      int phase;

      // Tracker state after reset, matching the block's register defaults.
      sample_ms = SAMPLE_INTERVAL_RESET;
      dflt_thr = DEFAULT_THRESHOLD_RESET;
      refractory_ms = REFRACTORY_RESET;
      timeout_ms = TIMEOUT_RESET;
      since_beat = '0;
      last_ivl = INTERVAL_RESET;
      foreach (ivl_hist[i]) ivl_hist[i] = '0;
      peak = LEVEL_MID;
      trough = LEVEL_MID;
      thr_level = DEFAULT_THRESHOLD_RESET;
      pulse = 1'b0;
      want_first = 1'b1;
      want_second = 1'b0;
      rate = '0;

      // Reset is held from the start and released on a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: sample extremes at the default registers, well inside the
      // refractory time and the interval guard, so only peak tracking can happen.
      choose_idling(1);
      queue_sample(0, 1'b0);
      queue_sample(1023, 1'b0);
      wait_drained();

      // Slowest time base, no refractory: first beat discarded, second seeds the
      // history and gives a rate, third updates it; a held peak keeps the pulse active.
      write_reg(CSR_SAMPLE_INTERVAL, 255);
      write_reg(CSR_REFRACTORY, 0);
      write_reg(CSR_TIMEOUT, 4095);
      queue_sample(0, 1'b0);
      queue_sample(1023, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(1023, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(1023, 1'b0);
      queue_sample(1023, 1'b0);
      wait_drained();

      // A sample that lands after the timeout returns the tracker to its defaults.
      write_reg(CSR_TIMEOUT, 500);
      queue_sample(0, 1'b0);
      queue_sample(1023, 1'b0);
      wait_drained();

      // Elapsed time saturates at its field maximum; with the largest timeout no
      // reset occurs, and a beat just past the refractory time reports the cap.
      write_reg(CSR_DEFAULT_THRESHOLD, 0);
      write_reg(CSR_TIMEOUT, 4095);
      write_reg(CSR_REFRACTORY, 4094);
      repeat (16) queue_sample(0, 1'b0);
      queue_sample(1023, 1'b0);
      wait_drained();

      // Shortest timeout: every sample returns to defaults with the top threshold.
      write_reg(CSR_DEFAULT_THRESHOLD, 1023);
      write_reg(CSR_TIMEOUT, 1);
      queue_sample(0, 1'b0);
      queue_sample(1023, 1'b0);
      queue_sample(600, 1'b0);
      wait_drained();

      // Random phases, each with its own register setting and idling style.
      phase = 0;
      while (random_items < RANDOM_TARGET) begin
         case (phase % 5)
            0: begin
               si = 20;
               thr = $urandom_range(400, 800);
               refr = 250;
               tmo = 2500;
               p_lo = 20;
               p_hi = 60;
            end
            1: begin
               si = 255;
               thr = 0;
               refr = 0;
               tmo = $urandom_range(2000, 4095);
               p_lo = 2;
               p_hi = 8;
            end
            2: begin
               si = 1;
               thr = 1023;
               refr = $urandom_range(0, 5);
               tmo = $urandom_range(20, 200);
               p_lo = 3;
               p_hi = 30;
            end
            3: begin
               si = $urandom_range(1, 255);
               thr = $urandom_range(0, 1023);
               refr = $urandom_range(0, 4095);
               tmo = $urandom_range(1, 4095);
               p_lo = 2;
               p_hi = 4095 / si + 2;
               if (p_hi > 60) p_hi = 60;
            end
            default: begin
               si = $urandom_range(30, 60);
               thr = $urandom_range(0, 1023);
               refr = $urandom_range(100, 400);
               tmo = $urandom_range(1500, 4095);
               p_lo = 10;
               p_hi = 40;
            end
         endcase
         write_reg(CSR_SAMPLE_INTERVAL, si);
         write_reg(CSR_DEFAULT_THRESHOLD, thr);
         write_reg(CSR_REFRACTORY, refr);
         write_reg(CSR_TIMEOUT, tmo);
         choose_idling(phase % 4);
         queue_rhythm(220, p_lo, p_hi);
         wait_drained();
         phase++;
      end

      // Let the back end settle, then make sure no expected result is still missing.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (reports_due.size() != 0) begin
         $error("%0d expected results never arrived.", reports_due.size());
         fail_count++;
      end
      $display("Summary: %0d samples checked over %0d register writes and %0d random phases.",
               samples_taken, writes_done, phase);
      $display("Summary: %0d beats counted, %0d beat timeouts, %0d failures.",
               beats_counted, timeouts_seen, fail_count);
      if (fail_count == 0) begin
         $display("heart_beat_detector_top verification clean");
      end else begin
         $display("heart_beat_detector_top verification failed");
      end
      $finish;
   end

endmodule
